@@ rtl/sse_pkg.sv @@
`timescale 1ns / 1ps

package sse_pkg;

  localparam int unsigned DefMaxSpan   = 32;
  localparam int unsigned DefTokenBits = 16;
  localparam int unsigned DefLossBits  = 16;

  localparam int unsigned ThrBits = 16;
  localparam int unsigned LenCfgBits = 6;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [ThrBits-1:0]    ThrReset = 16'd512;
  localparam logic [LenCfgBits-1:0] MinReset = 6'd1;
  localparam logic [LenCfgBits-1:0] MaxReset = 6'd32;

  localparam logic [CfgIdxBits-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MIN_LEN   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_LEN   = 2'd2;

  localparam int unsigned WeightFloor = 26;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLOSE,
    S_FLUSH,
    S_POST
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ rtl/surprise_span_extractor.sv @@
`timescale 1ns / 1ps

// Flow: a quiet or extending beat is taken in S_IDLE; a closing beat then passes through
// S_CLOSE, S_FLUSH (entries emitted if the span is long enough) and S_POST, twice over
// when a full span is followed by a document end. Throughput: 1 beat per cycle while
// nothing closes; entries leave at 1 per cycle unless the output stalls, shifted out
// of the cell row toward cell 0. Reset (async, active low): span closed and empty,
// output empty, registers to 512 / 1 / 32. The cell row holds no reset value.
module surprise_span_extractor #(
  parameter int unsigned MAX_SPAN   = sse_pkg::DefMaxSpan,
  parameter int unsigned TOKEN_BITS = sse_pkg::DefTokenBits,
  parameter int unsigned LOSS_BITS  = sse_pkg::DefLossBits,
  localparam int unsigned DataBits  = 2 * TOKEN_BITS + LOSS_BITS,
  localparam int unsigned BusBits   = ((DataBits + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sse_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [sse_pkg::CfgDataBits-1:0] cfg_data_i,
  // token_now, token_following, position_loss
  input  logic [BusBits-1:0]              s_axis_tdata,
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // span_token, span_target, novelty_weight
  output logic [BusBits-1:0]              m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);
  import sse_pkg::*;

  localparam int unsigned LenBits = $clog2(MAX_SPAN + 1);
  localparam int unsigned CmpBits = (LenBits > LenCfgBits) ? LenBits : LenCfgBits;
  localparam int unsigned LCmp    = (LOSS_BITS > ThrBits) ? LOSS_BITS : ThrBits;

  logic [ThrBits-1:0]    thr_q;
  logic [LenCfgBits-1:0] min_q, max_q;

  state_e state_q, state_d;
  logic               open_q, open_d;
  logic [LenBits-1:0] len_q, len_d;
  logic [LenBits-1:0] rem_q, rem_d;
  logic               pend_app_q, pend_app_d;
  logic               pend_end_q, pend_end_d;
  logic [DataBits-1:0] hold_q, hold_d;

  logic                 ovalid_q, ovalid_d;
  logic                 olast_q, olast_d;
  logic [DataBits-1:0]  odata_q, odata_d;

  logic [DataBits-1:0] cell_data [MAX_SPAN];
  cell_ctrl_t          cell_ctrl [MAX_SPAN];
  logic                load_any;
  logic [LenBits-1:0]  load_idx;
  logic                shift_en;
  logic [DataBits-1:0] load_data;

  logic               accept;
  logic               surprising;
  logic [CmpBits-1:0] eff_max;
  logic               at_max;
  logic               emit_ok;
  logic               out_free;
  logic [LOSS_BITS-1:0] head_loss;
  logic [LOSS_BITS-1:0] weight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      min_q <= MinReset;
      max_q <= MaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i[ThrBits-1:0];
        CFG_MIN_LEN:   min_q <= cfg_data_i[LenCfgBits-1:0];
        CFG_MAX_LEN:   max_q <= cfg_data_i[LenCfgBits-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = s_axis_tvalid && (state_q == S_IDLE);
  assign surprising = LCmp'(s_axis_tdata[2*TOKEN_BITS +: LOSS_BITS]) > LCmp'(thr_q);
  assign eff_max    = (CmpBits'(max_q) > CmpBits'(MAX_SPAN)) ? CmpBits'(MAX_SPAN)
                                                             : CmpBits'(max_q);
  assign at_max     = CmpBits'(len_q) >= eff_max;
  assign emit_ok    = open_q && (CmpBits'(len_q) >= CmpBits'(min_q));
  assign out_free   = !ovalid_q || m_axis_tready;

  assign head_loss = cell_data[0][2*TOKEN_BITS +: LOSS_BITS];
  assign weight    = (head_loss < LOSS_BITS'(WeightFloor)) ? LOSS_BITS'(WeightFloor)
                                                           : head_loss;

  always_comb begin
    state_d    = state_q;
    open_d     = open_q;
    len_d      = len_q;
    rem_d      = rem_q;
    pend_app_d = pend_app_q;
    pend_end_d = pend_end_q;
    hold_d     = hold_q;
    ovalid_d   = ovalid_q && !m_axis_tready;
    olast_d    = olast_q;
    odata_d    = odata_q;
    s_axis_tready = 1'b0;
    load_any   = 1'b0;
    load_idx   = len_q;
    load_data  = s_axis_tdata[DataBits-1:0];
    shift_en   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          hold_d = s_axis_tdata[DataBits-1:0];
          if (surprising && open_q && at_max) begin
            pend_app_d = 1'b1;
            pend_end_d = s_axis_tlast;
            state_d    = S_CLOSE;
          end else if (surprising) begin
            load_any = 1'b1;
            len_d    = len_q + LenBits'(1);
            open_d   = 1'b1;
            if (s_axis_tlast) begin
              pend_app_d = 1'b0;
              pend_end_d = 1'b0;
              state_d    = S_CLOSE;
            end
          end else if (open_q) begin
            pend_app_d = 1'b0;
            pend_end_d = 1'b0;
            state_d    = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (emit_ok && len_q != '0) begin
          rem_d   = len_q;
          state_d = S_FLUSH;
        end else begin
          open_d  = 1'b0;
          len_d   = '0;
          state_d = S_POST;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = {weight, cell_data[0][2*TOKEN_BITS-1:0]};
          olast_d  = (rem_q == LenBits'(1));
          shift_en = 1'b1;
          rem_d    = rem_q - LenBits'(1);
          if (rem_q == LenBits'(1)) begin
            open_d  = 1'b0;
            len_d   = '0;
            state_d = S_POST;
          end
        end
      end
      S_POST: begin
        if (pend_app_q) begin
          load_any   = 1'b1;
          load_idx   = '0;
          load_data  = hold_q;
          len_d      = LenBits'(1);
          open_d     = 1'b1;
          pend_app_d = 1'b0;
          if (pend_end_q) begin
            pend_end_d = 1'b0;
            state_d    = S_CLOSE;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      open_q     <= 1'b0;
      len_q      <= '0;
      rem_q      <= '0;
      pend_app_q <= 1'b0;
      pend_end_q <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      open_q     <= open_d;
      len_q      <= len_d;
      rem_q      <= rem_d;
      pend_app_q <= pend_app_d;
      pend_end_q <= pend_end_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q  <= hold_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  for (genvar k = 0; k < MAX_SPAN; k++) begin : g_cell
    logic [DataBits-1:0] next_data;
    if (k == MAX_SPAN - 1) begin : g_tail
      assign next_data = cell_data[k];
    end else begin : g_body
      assign next_data = cell_data[k+1];
    end
    assign cell_ctrl[k].load  = load_any && (load_idx == LenBits'(k));
    assign cell_ctrl[k].shift = shift_en;

    sse_cell #(
      .DataBits(DataBits)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[k]),
      .load_data_i(load_data),
      .next_data_i(next_data),
      .data_o     (cell_data[k])
    );
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = BusBits'(odata_q);

endmodule

@@ rtl/sse_cell.sv @@
`timescale 1ns / 1ps

module sse_cell #(
  parameter int unsigned DataBits = 48
) (
  input  logic                 clk_i,
  input  sse_pkg::cell_ctrl_t  ctrl_i,
  input  logic [DataBits-1:0]  load_data_i,
  input  logic [DataBits-1:0]  next_data_i,
  output logic [DataBits-1:0]  data_o
);
  import sse_pkg::*;

  logic [DataBits-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= load_data_i;
    end else if (ctrl_i.shift) begin
      data_q <= next_data_i;
    end
  end

  assign data_o = data_q;

endmodule
